// File: hw/rtl/assert_macros.svh
// Assertion helpers, included by md5_hash_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication from one cycle into the next.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: hw/rtl/md5_pkg.sv
`default_nettype none
package md5_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] COUNT_FULL = 3'd4;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_STEP = 6'd63;
   localparam logic [1:0] LAST_INDEX = 2'd3;

   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423f7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   function automatic logic [4:0] md5_rot(input logic [1:0] rnd, input logic [1:0] sub);
      logic [4:0] r;
      r = 5'd7;
      unique case ({rnd, sub})
         4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
         4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
         4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'hA: r = 5'd16;  4'hB: r = 5'd23;
         4'hC: r = 5'd6;   4'hD: r = 5'd10;  4'hE: r = 5'd15;  4'hF: r = 5'd21;
         default: r = 5'd7;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  cnt;
      logic        last;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BYTE, ST_COMP, ST_ADD, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA, PH_PAD80, PH_ZERO, PH_LEN
   } phase_type;

endpackage
`default_nettype wire

// File: hw/rtl/md5_front.sv
`default_nettype none
module md5_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [31:0]      req_data_word,
   input  wire logic [2:0]       req_byte_count,
   input  wire logic             req_last_item,
   output logic                  q_valid,
   output md5_pkg::item_type     q_item,
   input  wire logic             q_pop
);
   import md5_pkg::*;

   item_type                store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_W:0]         fill_ff, fill_in;
   logic                    push;
   item_type                item_new;

   // Counts above four are taken as a full word.
   always_comb begin
      item_new.data = req_data_word;
      item_new.cnt  = (req_byte_count > COUNT_FULL) ? COUNT_FULL : req_byte_count;
      item_new.last = req_last_item;
   end

   assign req_stall = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = store_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = q_pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wptr_ff] <= item_new;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/md5_back.sv
`default_nettype none
module md5_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire md5_pkg::item_type q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [31:0]          rsp_digest_word,
   output logic [1:0]           rsp_word_index,
   output logic                 rsp_last_word
);
   import md5_pkg::*;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   logic [5:0]   pos_ff;
   logic [63:0]  bits_ff;
   logic [31:0]  data_ff;
   logic [2:0]   rem_ff;
   logic         last_ff;
   logic [5:0]   step_ff;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff;
   logic [31:0]  cv_ff [4];
   logic [31:0]  buf_ff [16];
   logic [1:0]   oidx_ff;

   logic         put_en, word_en, wrap, out_take;
   logic [7:0]   put_byte;
   logic [5:0]   pos_adv;
   logic [1:0]   rnd;
   logic [3:0]   g;
   logic [31:0]  f, sum;
   logic [63:0]  rot_wide;
   logic [31:0]  b_new;

   assign out_take = (state_ff == ST_OUT) && !rsp_stall;
   assign pos_adv  = word_en ? pos_ff + 6'd4 : pos_ff + 6'd1;
   assign wrap     = (put_en || word_en) && (pos_adv == 6'd0);

   // One MD5 step per cycle.
   always_comb begin
      rnd = step_ff[5:4];
      unique case (rnd)
         2'd0: begin
            f = (b_ff & c_ff) | (~b_ff & d_ff);
            g = step_ff[3:0];
         end
         2'd1: begin
            f = (b_ff & d_ff) | (c_ff & ~d_ff);
            g = step_ff[3:0] * 4'd5 + 4'd1;
         end
         2'd2: begin
            f = b_ff ^ c_ff ^ d_ff;
            g = step_ff[3:0] * 4'd3 + 4'd5;
         end
         default: begin
            f = c_ff ^ (b_ff | ~d_ff);
            g = step_ff[3:0] * 4'd7;
         end
      endcase
      sum      = a_ff + f + buf_ff[g] + MD5_K[step_ff];
      rot_wide = {32'd0, sum} << md5_rot(rnd, step_ff[1:0]);
      b_new    = b_ff + (rot_wide[31:0] | rot_wide[63:32]);
   end

   // Control outputs of the sequencer.
   always_comb begin
      q_pop    = 1'b0;
      put_en   = 1'b0;
      word_en  = 1'b0;
      put_byte = 8'd0;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               phase_in = PH_DATA;
            end
         end
         ST_BYTE: begin
            unique case (phase_ff)
               PH_DATA: begin
                  if (rem_ff == 3'd0) begin
                     if (last_ff) begin
                        phase_in = PH_PAD80;
                     end
                  end else if (pos_ff[1:0] == 2'd0 && rem_ff == COUNT_FULL) begin
                     word_en = 1'b1;
                  end else begin
                     put_en   = 1'b1;
                     put_byte = data_ff[7:0];
                  end
               end
               PH_PAD80: begin
                  put_en   = 1'b1;
                  put_byte = 8'h80;
                  phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  if (pos_ff == LEN_OFFSET) begin
                     phase_in = PH_LEN;
                  end else begin
                     put_en = 1'b1;
                  end
               end
               default: begin
                  put_en   = 1'b1;
                  put_byte = bits_ff[{pos_ff[2:0], 3'b000} +: 8];
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (wrap) begin
               state_in = ST_COMP;
            end else if (phase_ff == PH_DATA && rem_ff == 3'd0 && !last_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_COMP: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = (phase_ff == PH_LEN) ? ST_OUT : ST_BYTE;
         end
         default: begin
            if (out_take && oidx_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DATA;
         pos_ff   <= '0;
         bits_ff  <= '0;
         oidx_ff  <= '0;
         cv_ff[0] <= IV_A;
         cv_ff[1] <= IV_B;
         cv_ff[2] <= IV_C;
         cv_ff[3] <= IV_D;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (word_en) begin
            bits_ff <= bits_ff + 64'd32;
         end else if (put_en && phase_ff == PH_DATA) begin
            bits_ff <= bits_ff + 64'd8;
         end
         if (put_en || word_en) begin
            pos_ff <= pos_adv;
         end
         if (state_ff == ST_ADD) begin
            cv_ff[0] <= cv_ff[0] + a_ff;
            cv_ff[1] <= cv_ff[1] + b_ff;
            cv_ff[2] <= cv_ff[2] + c_ff;
            cv_ff[3] <= cv_ff[3] + d_ff;
         end
         if (out_take) begin
            oidx_ff <= oidx_ff + 2'd1;
            if (oidx_ff == LAST_INDEX) begin
               cv_ff[0] <= IV_A;
               cv_ff[1] <= IV_B;
               cv_ff[2] <= IV_C;
               cv_ff[3] <= IV_D;
               pos_ff   <= '0;
               bits_ff  <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_item.data;
         rem_ff  <= q_item.cnt;
         last_ff <= q_item.last;
      end else if (word_en) begin
         rem_ff <= 3'd0;
      end else if (put_en && phase_ff == PH_DATA) begin
         data_ff <= {8'd0, data_ff[31:8]};
         rem_ff  <= rem_ff - 3'd1;
      end
      if (wrap) begin
         a_ff    <= cv_ff[0];
         b_ff    <= cv_ff[1];
         c_ff    <= cv_ff[2];
         d_ff    <= cv_ff[3];
         step_ff <= '0;
      end else if (state_ff == ST_COMP) begin
         a_ff    <= d_ff;
         d_ff    <= c_ff;
         c_ff    <= b_ff;
         b_ff    <= b_new;
         step_ff <= step_ff + 6'd1;
      end
   end

   // Block buffer; a word's first byte clears its upper bytes.
   always_ff @(posedge clock) begin
      if (word_en) begin
         buf_ff[pos_ff[5:2]] <= data_ff;
      end else if (put_en) begin
         if (pos_ff[1:0] == 2'd0) begin
            buf_ff[pos_ff[5:2]] <= {24'd0, put_byte};
         end else begin
            buf_ff[pos_ff[5:2]][{pos_ff[1:0], 3'b000} +: 8] <= put_byte;
         end
      end
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = cv_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == LAST_INDEX);

endmodule
`default_nettype wire

// File: hw/rtl/md5_hash_engine.sv
// An item waits in a four-entry queue; it is then fetched, its bytes are written one at a
// time, or as a single full word on a word boundary, and a closing step follows.
// Each completed 64-byte block runs through the compression unit in 64 steps and one add.
// On the last item, padding is written byte by byte plus compressions; the four digest
// words then leave one per accepted cycle. New items queue while the back end is busy.
// Synchronous active-high reset loads the initial chaining values and empties the queue.
`default_nettype none
`include "assert_macros.svh"
module md5_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_item,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import md5_pkg::*;

   // The front end clamps the byte count and queues each item, so the
   // input keeps flowing while the back end compresses a block, until the queue is full.
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   md5_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // The back end packs bytes into the block buffer, pads the message,
   // runs one MD5 step per cycle and hands out the digest.
   md5_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // The digest words leave in order A, B, C, D without gaps.
   `ASSERT_NEXT(a_index_steps, clock, reset, rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 2'd1, "digest index did not advance")
   // After word D is taken the engine is back to collecting input.
   `ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid && !rsp_stall && rsp_last_word, !rsp_valid, "result still shown after word D")
   // A result sequence always starts with word A.
   `ASSERT_CLK(a_start_a, clock, reset, $rose(rsp_valid) |-> rsp_word_index == 2'd0, "digest did not start at word A")
   // The back end takes an item only from a queue that holds one.
   `ASSERT_CLK(a_queue_flow, clock, reset, q_pop |-> q_valid, "pop from an empty queue")

endmodule
`default_nettype wire
